// ----- rtl/core/sbb_pkg.sv -----
// Shared types and constants for the separable box blur.
package sbb_pkg;

   localparam int unsigned CHAN_W  = 8;
   localparam int unsigned COLOR_W = 3 * CHAN_W;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_RADIUS = 2'd2,
      CSR_PASSES = 2'd3
   } csr_index_type;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_READ = 1'b1
   } kind_type;

endpackage

// ----- rtl/core/sbb_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module sbb_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/core/sbb_div.sv -----
// Iterative restoring divider: one quotient bit per cycle.
module sbb_div #(
   parameter int unsigned NUM_W = 14,
   parameter int unsigned DEN_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff;
   logic [DEN_W:0]   rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic             fits;

   always_comb begin
      trial = {rem_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      fits  = trial >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            q_ff    <= numer;
            rem_ff  <= '0;
            den_ff  <= denom;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            rem_ff <= fits ? trial - {1'b0, den_ff} : trial;
            q_ff   <= {q_ff[NUM_W-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// ----- rtl/core/separable_box_blur_top.sv -----
// Separable box blur: frame store, running-sum passes, one shared divider.
// A load is written into the frame store in the cycle it is accepted; a read's data
// passes the RAM read register and then the response register, and no request is
// taken while a read is pending or a response is stalled. After the last load, if
// the pass count is nonzero, the blur runs its passes through the single memory read
// port and the one shared bit-serial divider; no request is accepted meanwhile.
// Synchronous active-high reset clears positions and sequencer and restores the CSRs.
module separable_box_blur_top #(
   parameter int unsigned MAX_WIDTH  = 256,
   parameter int unsigned MAX_HEIGHT = 256,
   parameter int unsigned MAX_RADIUS = 31
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_red_in,
   input  logic [7:0] req_green_in,
   input  logic [7:0] req_blue_in,
   input  logic [7:0] req_alpha_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_red_out,
   output logic [7:0] rsp_green_out,
   output logic [7:0] rsp_blue_out,
   output logic [7:0] rsp_alpha_out,
   output logic       rsp_frame_end,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [8:0] csr_data
);

   localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned PW     = $clog2(DEPTH + 1);
   localparam int unsigned XW     = $clog2(MAX_WIDTH + 1);
   localparam int unsigned YW     = $clog2(MAX_HEIGHT + 1);
   localparam int unsigned LW     = (XW > YW) ? XW : YW;
   localparam int unsigned RW     = $clog2(MAX_RADIUS + 1);
   localparam int unsigned KW     = $clog2(2 * MAX_RADIUS + 2);
   localparam int unsigned NUM_W  = $clog2((2 * MAX_RADIUS + 1) * 255 + 1);
   localparam int unsigned IW     = LW + 2;
   localparam int unsigned CW     = sbb_pkg::CHAN_W;
   localparam int unsigned CLW    = sbb_pkg::COLOR_W;

   typedef enum logic [3:0] {
      S_IDLE, S_PRIME_RD, S_PRIME_WT, S_PRIME_ACC, S_ADD_RD, S_SUB_RD,
      S_WT, S_ADD_ACC, S_DIV, S_DIV_WT, S_WRITE
   } state_type;

   // configuration
   logic [8:0] width_ff, height_ff;
   logic [4:0] radius_ff;
   logic [3:0] passes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
         radius_ff <= 5'd1;
         passes_ff <= 4'd1;
      end else if (csr_write) begin
         unique case (sbb_pkg::csr_index_type'(csr_index))
            sbb_pkg::CSR_WIDTH:  width_ff  <= csr_data;
            sbb_pkg::CSR_HEIGHT: height_ff <= csr_data;
            sbb_pkg::CSR_RADIUS: radius_ff <= csr_data[4:0];
            sbb_pkg::CSR_PASSES: passes_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   logic [XW-1:0] eff_w;
   logic [YW-1:0] eff_h;
   logic [RW-1:0] eff_r;
   logic [PW-1:0] total;

   always_comb begin
      if (width_ff == 9'd0)                       eff_w = XW'(1);
      else if (32'(width_ff) > MAX_WIDTH)         eff_w = XW'(MAX_WIDTH);
      else                                        eff_w = XW'(width_ff);
      if (height_ff == 9'd0)                      eff_h = YW'(1);
      else if (32'(height_ff) > MAX_HEIGHT)       eff_h = YW'(MAX_HEIGHT);
      else                                        eff_h = YW'(height_ff);
      if (32'(radius_ff) > MAX_RADIUS)            eff_r = RW'(MAX_RADIUS);
      else                                        eff_r = RW'(radius_ff);
      total = PW'(eff_w * eff_h);
   end

   // memories
   logic           cs_we, ab_we, pb_we;
   logic [AW-1:0]  cs_wa, pb_wa, cs_ra, pb_ra, ab_ra;
   logic [CLW-1:0] cs_wd, pb_wd, cs_rd, pb_rd;
   logic [CW-1:0]  ab_rd;

   sbb_ram #(.WIDTH(CLW), .DEPTH(DEPTH)) u_color (
      .clock(clock), .wr_en(cs_we), .wr_addr(cs_wa), .wr_data(cs_wd),
      .rd_addr(cs_ra), .rd_data(cs_rd));
   sbb_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_alpha (
      .clock(clock), .wr_en(ab_we), .wr_addr(cs_wa), .wr_data(req_alpha_in),
      .rd_addr(ab_ra), .rd_data(ab_rd));
   sbb_ram #(.WIDTH(CLW), .DEPTH(DEPTH)) u_pass (
      .clock(clock), .wr_en(pb_we), .wr_addr(pb_wa), .wr_data(pb_wd),
      .rd_addr(pb_ra), .rd_data(pb_rd));

   // sequencer state
   state_type              state_ff;
   logic [PW-1:0]          load_pos_ff, read_pos_ff;
   logic [3:0]             pass_ff;
   logic                   vert_ff;
   logic [LW-1:0]          line_ff, x_ff;
   logic signed [IW-1:0]   prime_i_ff;
   logic [NUM_W-1:0]       sum_ff [3];
   logic [CW-1:0]          sub_px_ff [3];
   logic [CW-1:0]          q_ff [3];
   logic [1:0]             ch_ff;
   logic                   rsp_valid_ff, rd_pend_ff, rd_last_ff;
   logic                   out_end_ff;
   logic [CW-1:0]          out_r_ff, out_g_ff, out_b_ff, out_a_ff;
   logic [CW-1:0]          add_r, add_g, add_b;

   logic [LW-1:0] line_len, line_cnt;
   logic [KW-1:0] k;
   assign line_len = vert_ff ? LW'(eff_h) : LW'(eff_w);
   assign line_cnt = vert_ff ? LW'(eff_w) : LW'(eff_h);
   assign k        = KW'({eff_r, 1'b1});

   function automatic logic [LW-1:0] clampi(input logic signed [IW-1:0] v,
                                            input logic [LW-1:0] len);
      logic signed [IW-1:0] last;
      begin
         last = $signed({2'b00, len}) - IW'(1);
         if (v < 0)          clampi = '0;
         else if (v > last)  clampi = LW'(last);
         else                clampi = LW'(v);
      end
   endfunction

   // address of sample i of the current line
   logic [LW-1:0]        samp;
   logic signed [IW-1:0] samp_i;
   logic [AW-1:0]        samp_addr;
   logic [CLW-1:0]       src_rd;

   always_comb begin
      unique case (state_ff)
         S_PRIME_RD, S_PRIME_WT: samp_i = prime_i_ff;
         S_ADD_RD:   samp_i = $signed({2'b00, x_ff}) + $signed(IW'(eff_r)) + IW'(1);
         default:    samp_i = $signed({2'b00, x_ff}) - $signed(IW'(eff_r));
      endcase
      samp = clampi(samp_i, line_len);
      if (vert_ff) samp_addr = AW'(32'(samp) * eff_w + 32'(line_ff));
      else         samp_addr = AW'(32'(line_ff) * eff_w + 32'(samp));
      src_rd = vert_ff ? pb_rd : cs_rd;
   end

   logic [AW-1:0] dst_addr;
   assign dst_addr = vert_ff ? AW'(32'(x_ff) * eff_w + 32'(line_ff))
                             : AW'(32'(line_ff) * eff_w + 32'(x_ff));

   // shared divider
   logic             div_start, div_done;
   logic [NUM_W-1:0] div_q;

   sbb_div #(.NUM_W(NUM_W), .DEN_W(KW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .numer(sum_ff[ch_ff]),
      .denom(k), .done(div_done), .quot(div_q));
   assign div_start = (state_ff == S_DIV);

   logic req_fire, rsp_fire, is_load, is_read, load_done;
   logic [PW-1:0] rpos, load_next;
   assign req_ready = (state_ff == S_IDLE) && !(rsp_valid_ff && !rsp_ready)
                      && !rd_pend_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign is_load   = req_fire && (sbb_pkg::kind_type'(req_kind) == sbb_pkg::KIND_LOAD);
   assign is_read   = req_fire && (sbb_pkg::kind_type'(req_kind) == sbb_pkg::KIND_READ);
   assign rpos      = (read_pos_ff >= total) ? '0 : read_pos_ff;
   assign load_next = load_pos_ff + 1'b1;
   assign load_done = load_next >= total;

   always_comb begin
      cs_we = 1'b0;
      ab_we = 1'b0;
      pb_we = 1'b0;
      cs_wa = AW'(load_pos_ff);
      cs_wd = {req_red_in, req_green_in, req_blue_in};
      pb_wa = dst_addr;
      pb_wd = {q_ff[0], q_ff[1], q_ff[2]};
      cs_ra = samp_addr;
      pb_ra = samp_addr;
      ab_ra = AW'(rpos);
      if (state_ff == S_IDLE) begin
         cs_ra = AW'(rpos);
         if (is_load && (32'(load_pos_ff) < DEPTH)) begin
            cs_we = 1'b1;
            ab_we = 1'b1;
         end
      end else if (state_ff == S_WRITE) begin
         if (vert_ff) begin
            cs_we = 1'b1;
            cs_wa = dst_addr;
            cs_wd = pb_wd;
         end else begin
            pb_we = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         load_pos_ff  <= '0;
         read_pos_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
         pass_ff      <= '0;
         vert_ff      <= 1'b0;
         line_ff      <= '0;
         x_ff         <= '0;
         ch_ff        <= '0;
         prime_i_ff   <= '0;
         for (int c = 0; c < 3; c++) sum_ff[c] <= '0;
      end else begin
         if (rsp_fire) rsp_valid_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
         if (rd_pend_ff) begin
            rsp_valid_ff <= 1'b1;
            out_r_ff     <= cs_rd[23:16];
            out_g_ff     <= cs_rd[15:8];
            out_b_ff     <= cs_rd[7:0];
            out_a_ff     <= ab_rd;
            out_end_ff   <= rd_last_ff;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (is_read) begin
                  rd_pend_ff  <= 1'b1;
                  rd_last_ff  <= rpos == total - 1'b1;
                  read_pos_ff <= (rpos + 1'b1 >= total) ? '0 : rpos + 1'b1;
               end
               if (is_load) begin
                  if (load_done) begin
                     load_pos_ff <= '0;
                     read_pos_ff <= '0;
                     pass_ff     <= '0;
                     vert_ff     <= 1'b0;
                     line_ff     <= '0;
                     if (passes_ff != 4'd0) begin
                        state_ff   <= S_PRIME_RD;
                        prime_i_ff <= -$signed(IW'(eff_r));
                        for (int c = 0; c < 3; c++) sum_ff[c] <= '0;
                     end
                  end else begin
                     load_pos_ff <= load_next;
                  end
               end
            end
            S_PRIME_RD: state_ff <= S_PRIME_WT;
            S_PRIME_WT: state_ff <= S_PRIME_ACC;
            S_PRIME_ACC: begin
               sum_ff[0] <= sum_ff[0] + NUM_W'(src_rd[23:16]);
               sum_ff[1] <= sum_ff[1] + NUM_W'(src_rd[15:8]);
               sum_ff[2] <= sum_ff[2] + NUM_W'(src_rd[7:0]);
               if (prime_i_ff == $signed(IW'(eff_r))) begin
                  state_ff <= S_SUB_RD;
                  x_ff     <= '0;
               end else begin
                  prime_i_ff <= prime_i_ff + IW'(1);
                  state_ff   <= S_PRIME_RD;
               end
            end
            S_SUB_RD: state_ff <= S_ADD_RD;
            S_ADD_RD: begin
               sub_px_ff[0] <= src_rd[23:16];
               sub_px_ff[1] <= src_rd[15:8];
               sub_px_ff[2] <= src_rd[7:0];
               state_ff     <= S_WT;
            end
            S_WT: state_ff <= S_ADD_ACC;
            S_ADD_ACC: begin
               // quotients of the current sums first
               ch_ff    <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: state_ff <= S_DIV_WT;
            S_DIV_WT: begin
               if (div_done) begin
                  q_ff[ch_ff] <= CW'(div_q);
                  if (ch_ff == 2'd2) begin
                     state_ff <= S_WRITE;
                  end else begin
                     ch_ff    <= ch_ff + 1'b1;
                     state_ff <= S_DIV;
                  end
               end
            end
            S_WRITE: begin
               if (x_ff != line_len - 1'b1) begin
                  x_ff     <= x_ff + 1'b1;
                  state_ff <= S_SUB_RD;
                  sum_ff[0] <= sum_ff[0] + NUM_W'(add_r) - NUM_W'(sub_px_ff[0]);
                  sum_ff[1] <= sum_ff[1] + NUM_W'(add_g) - NUM_W'(sub_px_ff[1]);
                  sum_ff[2] <= sum_ff[2] + NUM_W'(add_b) - NUM_W'(sub_px_ff[2]);
               end else begin
                  for (int c = 0; c < 3; c++) sum_ff[c] <= '0;
                  prime_i_ff <= -$signed(IW'(eff_r));
                  if (line_ff != line_cnt - 1'b1) begin
                     line_ff  <= line_ff + 1'b1;
                     state_ff <= S_PRIME_RD;
                  end else begin
                     line_ff <= '0;
                     if (!vert_ff) begin
                        vert_ff  <= 1'b1;
                        state_ff <= S_PRIME_RD;
                     end else if (pass_ff + 1'b1 == passes_ff) begin
                        vert_ff  <= 1'b0;
                        state_ff <= S_IDLE;
                     end else begin
                        vert_ff  <= 1'b0;
                        pass_ff  <= pass_ff + 1'b1;
                        state_ff <= S_PRIME_RD;
                     end
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // add-side pixel, captured when its read lands
   always_ff @(posedge clock) begin
      if (state_ff == S_WT) begin
         add_r <= src_rd[23:16];
         add_g <= src_rd[15:8];
         add_b <= src_rd[7:0];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = out_r_ff;
   assign rsp_green_out = out_g_ff;
   assign rsp_blue_out  = out_b_ff;
   assign rsp_alpha_out = out_a_ff;
   assign rsp_frame_end = out_end_ff;

   ap_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready) else $error("ready while blurring");
   ap_rd_to_rsp: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |=> rsp_valid_ff) else $error("read lost");
   ap_div_done: assert property (@(posedge clock) disable iff (reset)
      div_start |=> !div_done) else $error("divider done too early");
   ap_load_bound: assert property (@(posedge clock) disable iff (reset)
      load_pos_ff < PW'(DEPTH)) else $error("load position past store");

endmodule

// ----- tb/sv/tb_separable_box_blur_top.sv -----
// Self-checking testbench for the separable box blur: loads frames, reads them back, checks.
module tb_separable_box_blur_top;

   localparam int unsigned DEPTH = 65536;
   localparam int unsigned IDLE_LIMIT = 800000;

   typedef struct packed {
      sbb_pkg::kind_type kind;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pixel_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       frame_end;
   } pixel_rsp_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_kind = 1'b0;
   logic [7:0] req_red_in = '0;
   logic [7:0] req_green_in = '0;
   logic [7:0] req_blue_in = '0;
   logic [7:0] req_alpha_in = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_red_out;
   logic [7:0] rsp_green_out;
   logic [7:0] rsp_blue_out;
   logic [7:0] rsp_alpha_out;
   logic       rsp_frame_end;
   logic       csr_write = 1'b0;
   logic [1:0] csr_index = '0;
   logic [8:0] csr_data = '0;

   separable_box_blur_top dut (.*);

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // shadow state of the block
   logic [23:0] color_mem [DEPTH];
   logic [23:0] pass_mem [DEPTH];
   logic [7:0]  alpha_mem [DEPTH];
   bit          loaded [DEPTH];
   int unsigned load_pos, read_pos;
   logic [8:0]  width_reg = 9'd256, height_reg = 9'd256;
   logic [4:0]  radius_reg = 5'd1;
   logic [3:0]  passes_reg = 4'd1;

   pixel_req_type pending_reqs[$];
   pixel_rsp_type expected_pixels[$];
   int errors, n_loads, n_reads, n_frames, n_checked;
   bit req_took;
   int idle_cycles;
   int burst_left, gap_left;
   int stall_cyc;

   function automatic int unsigned eff_w();
      if (width_reg == 0) return 1;
      return width_reg > 256 ? 256 : width_reg;
   endfunction

   function automatic int unsigned eff_h();
      if (height_reg == 0) return 1;
      return height_reg > 256 ? 256 : height_reg;
   endfunction

   function automatic int clampi(int v, int hi);
      if (v < 0) return 0;
      return v > hi ? hi : v;
   endfunction

   task automatic blur_frame();
      int w, h, r, k;
      int s0, s1, s2;
      logic [23:0] px;
      w = eff_w();
      h = eff_h();
      r = radius_reg;
      k = 2 * r + 1;
      for (int p = 0; p < passes_reg; p++) begin
         for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++) begin
               s0 = 0; s1 = 0; s2 = 0;
               for (int t = -r; t <= r; t++) begin
                  px = color_mem[y * w + clampi(x + t, w - 1)];
                  s0 += px[23:16]; s1 += px[15:8]; s2 += px[7:0];
               end
               pass_mem[y * w + x] = {8'(s0 / k), 8'(s1 / k), 8'(s2 / k)};
            end
         for (int x = 0; x < w; x++)
            for (int y = 0; y < h; y++) begin
               s0 = 0; s1 = 0; s2 = 0;
               for (int t = -r; t <= r; t++) begin
                  px = pass_mem[clampi(y + t, h - 1) * w + x];
                  s0 += px[23:16]; s1 += px[15:8]; s2 += px[7:0];
               end
               color_mem[y * w + x] = {8'(s0 / k), 8'(s1 / k), 8'(s2 / k)};
            end
      end
   endtask

   task automatic send_load(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
      pixel_req_type it;
      it = '{sbb_pkg::KIND_LOAD, r, g, b, a};
      pending_reqs.push_back(it);
      n_loads++;
      if (load_pos < DEPTH) begin
         color_mem[load_pos] = {r, g, b};
         alpha_mem[load_pos] = a;
         loaded[load_pos] = 1'b1;
      end
      load_pos++;
      if (load_pos >= eff_w() * eff_h()) begin
         blur_frame();
         n_frames++;
         load_pos = 0;
         read_pos = 0;
      end
   endtask

   // issues a read only when the pixel it would return was loaded at some point
   task automatic try_read(output bit issued);
      int unsigned total;
      pixel_req_type it;
      pixel_rsp_type ex;
      total = eff_w() * eff_h();
      if (read_pos >= total) read_pos = 0;
      issued = loaded[read_pos];
      if (!issued) return;
      it = '{sbb_pkg::KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
      pending_reqs.push_back(it);
      ex = '{color_mem[read_pos][23:16], color_mem[read_pos][15:8], color_mem[read_pos][7:0],
             alpha_mem[read_pos], read_pos == total - 1};
      expected_pixels.push_back(ex);
      n_reads++;
      read_pos++;
      if (read_pos >= total) read_pos = 0;
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic write_csr(sbb_pkg::csr_index_type idx, logic [8:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         sbb_pkg::CSR_WIDTH:  width_reg  = value;
         sbb_pkg::CSR_HEIGHT: height_reg = value[8:0];
         sbb_pkg::CSR_RADIUS: radius_reg = value[4:0];
         sbb_pkg::CSR_PASSES: passes_reg = value[3:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [8:0] w, logic [8:0] h, logic [4:0] r, logic [3:0] p);
      wait_idle();
      write_csr(sbb_pkg::CSR_WIDTH, w);
      write_csr(sbb_pkg::CSR_HEIGHT, h);
      write_csr(sbb_pkg::CSR_RADIUS, 9'(r));
      write_csr(sbb_pkg::CSR_PASSES, 9'(p));
   endtask

   task automatic rand_load();
      send_load(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic read_n(int n);
      bit ok;
      for (int i = 0; i < n; i++) try_read(ok);
   endtask

   // one full frame, reads mixed into the load stream, then a full read-back
   task automatic random_frame(logic [8:0] w, logic [8:0] h, logic [4:0] r, logic [3:0] p);
      int unsigned total;
      bit ok;
      configure(w, h, r, p);
      total = eff_w() * eff_h();
      for (int unsigned i = 0; i < total; i++) begin
         if ($urandom_range(0, 4) == 0) try_read(ok);
         rand_load();
      end
      read_n(total + $urandom_range(1, 3));
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on pixel read %0d: %s got %0d expected %0d", n_checked, what, got, want);
      errors++;
   endtask

   // request driver: bursts with random gaps
   always @(negedge clock) begin
      pixel_req_type it;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!req_valid || req_took) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            it = pending_reqs.pop_front();
            req_valid    <= 1'b1;
            req_kind     <= it.kind;
            req_red_in   <= it.red;
            req_green_in <= it.green;
            req_blue_in  <= it.blue;
            req_alpha_in <= it.alpha;
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall pattern
   always @(negedge clock) begin
      stall_cyc <= stall_cyc + 1;
      case (stall_cyc[7:6])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= $urandom_range(0, 1);
         2'd2: rsp_ready <= stall_cyc[1:0] == 2'd3;
         default: rsp_ready <= $urandom_range(0, 7) != 0;
      endcase
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      pixel_rsp_type ex;
      req_took <= req_valid && req_ready;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired with %0d pixels outstanding", expected_pixels.size());
            $display("TEST FAILED");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected response", 1, 0);
            end else begin
               ex = expected_pixels.pop_front();
               if (rsp_red_out !== ex.red) report_mismatch("red", rsp_red_out, ex.red);
               if (rsp_green_out !== ex.green) report_mismatch("green", rsp_green_out, ex.green);
               if (rsp_blue_out !== ex.blue) report_mismatch("blue", rsp_blue_out, ex.blue);
               if (rsp_alpha_out !== ex.alpha) report_mismatch("alpha", rsp_alpha_out, ex.alpha);
               if (rsp_frame_end !== ex.frame_end)
                  report_mismatch("frame_end", rsp_frame_end, ex.frame_end);
            end
            n_checked++;
         end
      end
   end

   initial begin
      stall_cyc = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // 2x2, no passes, channel extremes
      configure(9'd2, 9'd2, 5'd0, 4'd0);
      send_load(8'h00, 8'h00, 8'h00, 8'h00);
      send_load(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_load(8'hFF, 8'h00, 8'hFF, 8'h00);
      send_load(8'h00, 8'hFF, 8'h00, 8'hFF);
      read_n(5);
      // max radius and passes, reads during load see raw pixels
      configure(9'd3, 9'd3, 5'd31, 4'd15);
      repeat (4) rand_load();
      read_n(2);
      repeat (5) rand_load();
      read_n(3);
      // frame shrinks while partly loaded
      configure(9'd4, 9'd4, 5'd1, 4'd1);
      repeat (3) rand_load();
      read_n(1);
      configure(9'd1, 9'd2, 5'd1, 4'd1);
      rand_load();
      read_n(3);

      // size extremes: zero size, saturating width, tiny frame at full radius
      random_frame(9'd0, 9'd0, 5'd2, 4'd3);
      configure(9'd511, 9'd1, 5'd31, 4'd1);
      repeat (256) rand_load();
      read_n(40);
      random_frame(9'd2, 9'd2, 5'd31, 4'd15);

      while (n_loads + n_reads < 500) begin
         if ($urandom_range(0, 9) == 0)
            random_frame(9'($urandom_range(1, 2)), 9'($urandom_range(1, 2)),
                         5'($urandom), 4'($urandom_range(8, 15)));
         else
            random_frame(9'($urandom_range(0, 6)), 9'($urandom_range(0, 6)),
                         5'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3)),
                         4'($urandom_range(0, 3)));
      end

      wait_idle();
      $display("%0d loads and %0d reads over %0d blurred frames, %0d pixels checked",
               n_loads, n_reads, n_frames, n_checked);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", errors);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/sbb_pkg.sv
rtl/core/sbb_ram.sv
rtl/core/sbb_div.sv
rtl/core/separable_box_blur_top.sv
tb/sv/tb_separable_box_blur_top.sv
